>>> design/bfpa_pkg.sv
// Shared types and constants for the best-fit pool allocator.
package bfpa_pkg;

   localparam int SIZE_BITS = 16;
   localparam logic [SIZE_BITS-1:0] POOL_RESET = 16'd16384;

   localparam logic OP_ACQUIRE = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BUSY    = 2'd1;
   localparam logic [1:0] ST_UNKNOWN = 2'd2;

   typedef struct packed {
      logic        operation;
      logic [15:0] req_size;
      logic [15:0] release_offset;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] granted_offset;
      logic [15:0] largest_free;
   } rsp_type;

endpackage

>>> design/best_fit_pool_allocator_core.sv
// Best-fit pool allocator: slot and free-segment tables in synchronous RAMs.
//
// A request is taken when start is high and busy is low; its response appears
// on rsp_data for one cycle with rsp_strobe and cannot be held off. One request
// is in flight at a time, and busy stays high through the response cycle.
// Every scan pass walks the single-read-port slot or segment RAM one entry per cycle.
// An accepted request runs a slot lookup (releases only), a segment scan and one
// decision state. When the table changes, it then moves entries one at a time through
// S_SHIFT_RD and S_SHIFT_WR, with S_PUT after them when a segment must still be written,
// or uses S_PUT alone for an in-place segment write. Last come a largest-segment scan
// and the response. An acquire with no free slot or an empty segment table, and a
// release with no matching slot, skip straight to the largest-segment scan. The
// longest case is a release that inserts a new first segment into a table of ten.
// Writing the pool size resets the tables to one free segment covering the pool.
module best_fit_pool_allocator_core #(
   parameter int MAX_SLOTS    = 10,
   parameter int MAX_SEGMENTS = 11,
   parameter int OFFSET_BITS  = 16,
   parameter int HEADER_BYTES = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  bfpa_pkg::req_type   req_data,
   output logic                rsp_strobe,
   output bfpa_pkg::rsp_type   rsp_data,
   input  logic                csr_we,
   input  logic [15:0]         csr_wdata
);
   import bfpa_pkg::*;

   localparam int SLOT_IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int SLOT_CW = $clog2(MAX_SLOTS + 1);
   localparam int SEG_IW  = $clog2(MAX_SEGMENTS);
   localparam int SEG_CW  = $clog2(MAX_SEGMENTS + 1);
   localparam int IDX_W   = (SEG_CW > SLOT_CW) ? SEG_CW : SLOT_CW;
   localparam int NEED_W  = SIZE_BITS + 1;
   localparam int E_W     = ((OFFSET_BITS > SIZE_BITS) ? OFFSET_BITS : SIZE_BITS) + 1;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_SLOT     = 4'd1;
   localparam logic [3:0] S_SCAN     = 4'd2;
   localparam logic [3:0] S_DECIDE   = 4'd3;
   localparam logic [3:0] S_SHIFT_RD = 4'd4;
   localparam logic [3:0] S_SHIFT_WR = 4'd5;
   localparam logic [3:0] S_PUT      = 4'd6;
   localparam logic [3:0] S_MAX      = 4'd7;
   localparam logic [3:0] S_RESP     = 4'd8;

   typedef struct packed {
      logic [OFFSET_BITS-1:0] ofs;
      logic [SIZE_BITS-1:0]   bytes;
   } entry_type;

   entry_type seg_mem  [MAX_SEGMENTS];
   entry_type slot_mem [MAX_SLOTS];

   logic [3:0]             state_ff, state_in;
   logic                   op_ff, op_in;
   logic [NEED_W-1:0]      need_ff, need_in;
   logic [OFFSET_BITS-1:0] ofs_ff, ofs_in;
   logic [SIZE_BITS-1:0]   size_ff, size_in;
   logic [SLOT_IW-1:0]     slot_ff, slot_in;
   logic                   found_ff, found_in;
   logic [NEED_W-1:0]      head_ff, head_in;
   logic [SEG_CW-1:0]      best_ff, best_in;
   entry_type              bsel_ff, bsel_in;
   entry_type              nsel_ff, nsel_in;
   logic                   has_next_ff, has_next_in;
   logic [SEG_CW-1:0]      below_ff, below_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [IDX_W-1:0]       pidx_ff, pidx_in;
   logic                   pend_ff, pend_in;
   logic [SEG_CW-1:0]      count_ff, count_in;
   logic [MAX_SLOTS-1:0]   used_ff, used_in;
   logic                   mode_rm_ff, mode_rm_in;
   logic [SEG_CW-1:0]      cur_ff, cur_in;
   logic [SEG_CW-1:0]      lim_ff, lim_in;
   logic                   put_pend_ff, put_pend_in;
   logic [SEG_CW-1:0]      put_addr_ff, put_addr_in;
   entry_type              put_data_ff, put_data_in;
   logic [1:0]             status_ff, status_in;
   logic [OFFSET_BITS-1:0] granted_ff, granted_in;
   logic [SIZE_BITS-1:0]   max_ff, max_in;

   entry_type              seg_rdata_ff, slot_rdata_ff;
   logic [SEG_IW-1:0]      seg_raddr, seg_waddr;
   logic [SLOT_IW-1:0]     slot_raddr, slot_waddr;
   logic                   seg_we, slot_we;
   entry_type              seg_wdata, slot_wdata;

   logic                   free_any;
   logic [SLOT_IW-1:0]     free_slot;
   logic [NEED_W-1:0]      need_calc;
   logic [NEED_W-1:0]      h_calc;
   logic [E_W-1:0]         rel_end;
   logic                   ins_req;
   logic [SEG_CW-1:0]      ins_k;

   always_comb begin
      free_any  = 1'b0;
      free_slot = '0;
      for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_any  = 1'b1;
            free_slot = SLOT_IW'(i);
         end
      end
   end

   always_comb begin
      if (32'(req_data.req_size) < 32'(HEADER_BYTES)) begin
         need_calc = NEED_W'(HEADER_BYTES);
      end else begin
         need_calc = (NEED_W'(req_data.req_size) + NEED_W'(3)) & ~NEED_W'(3);
      end
   end

   assign h_calc  = NEED_W'(seg_rdata_ff.bytes) - need_ff;
   assign rel_end = E_W'(ofs_ff) + E_W'(size_ff);

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      need_in     = need_ff;
      ofs_in      = ofs_ff;
      size_in     = size_ff;
      slot_in     = slot_ff;
      found_in    = found_ff;
      head_in     = head_ff;
      best_in     = best_ff;
      bsel_in     = bsel_ff;
      nsel_in     = nsel_ff;
      has_next_in = has_next_ff;
      below_in    = below_ff;
      idx_in      = idx_ff;
      pidx_in     = pidx_ff;
      pend_in     = pend_ff;
      count_in    = count_ff;
      used_in     = used_ff;
      mode_rm_in  = mode_rm_ff;
      cur_in      = cur_ff;
      lim_in      = lim_ff;
      put_pend_in = put_pend_ff;
      put_addr_in = put_addr_ff;
      put_data_in = put_data_ff;
      status_in   = status_ff;
      granted_in  = granted_ff;
      max_in      = max_ff;
      seg_raddr   = idx_ff[SEG_IW-1:0];
      slot_raddr  = idx_ff[SLOT_IW-1:0];
      seg_we      = 1'b0;
      seg_waddr   = '0;
      seg_wdata   = '0;
      slot_we     = 1'b0;
      slot_waddr  = slot_ff;
      slot_wdata  = '0;
      ins_req     = 1'b0;
      ins_k       = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in       = req_data.operation;
               need_in     = need_calc;
               ofs_in      = OFFSET_BITS'(req_data.release_offset);
               slot_in     = free_slot;
               found_in    = 1'b0;
               has_next_in = 1'b0;
               below_in    = '0;
               put_pend_in = 1'b0;
               status_in   = ST_OK;
               granted_in  = '0;
               if (req_data.operation == OP_RELEASE) begin
                  state_in = S_SLOT;
               end else if (free_any && count_ff != '0) begin
                  state_in = S_SCAN;
               end else begin
                  status_in = ST_BUSY;
                  state_in  = S_MAX;
               end
            end
         end

         S_SLOT: begin
            if (pend_ff && used_ff[pidx_ff[SLOT_IW-1:0]] && slot_rdata_ff.ofs == ofs_ff) begin
               slot_in                        = pidx_ff[SLOT_IW-1:0];
               size_in                        = slot_rdata_ff.bytes;
               used_in[pidx_ff[SLOT_IW-1:0]]  = 1'b0;
               state_in                       = S_SCAN;
            end else if (idx_ff < IDX_W'(MAX_SLOTS)) begin
               pend_in = 1'b1;
               pidx_in = idx_ff;
               idx_in  = idx_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  status_in = ST_UNKNOWN;
                  state_in  = S_MAX;
               end
            end
         end

         S_SCAN: begin
            if (pend_ff) begin
               if (op_ff == OP_ACQUIRE) begin
                  if (NEED_W'(seg_rdata_ff.bytes) > need_ff &&
                      (!found_ff || h_calc < head_ff)) begin
                     found_in = 1'b1;
                     head_in  = h_calc;
                     best_in  = SEG_CW'(pidx_ff);
                     bsel_in  = seg_rdata_ff;
                  end
               end else begin
                  if (pidx_ff == '0) begin
                     below_in    = '0;
                     bsel_in     = seg_rdata_ff;
                     has_next_in = 1'b0;
                  end else if (seg_rdata_ff.ofs < ofs_ff) begin
                     below_in    = SEG_CW'(pidx_ff);
                     bsel_in     = seg_rdata_ff;
                     has_next_in = 1'b0;
                  end else if (SEG_CW'(pidx_ff) == below_ff + 1'b1) begin
                     nsel_in     = seg_rdata_ff;
                     has_next_in = 1'b1;
                  end
               end
            end
            if (idx_ff < IDX_W'(count_ff)) begin
               pend_in = 1'b1;
               pidx_in = idx_ff;
               idx_in  = idx_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = S_DECIDE;
               end
            end
         end

         S_DECIDE: begin
            state_in = S_MAX;
            if (op_ff == OP_ACQUIRE) begin
               if (!found_ff) begin
                  status_in = ST_BUSY;
               end else begin
                  used_in[slot_ff] = 1'b1;
                  slot_we          = 1'b1;
                  slot_wdata.ofs   = bsel_ff.ofs;
                  granted_in       = bsel_ff.ofs;
                  if (head_ff <= NEED_W'(HEADER_BYTES)) begin
                     slot_wdata.bytes = bsel_ff.bytes;
                     mode_rm_in       = 1'b1;
                     cur_in           = best_ff;
                     lim_in           = count_ff - 1'b1;
                     count_in         = count_ff - 1'b1;
                     state_in         = S_SHIFT_RD;
                  end else begin
                     slot_wdata.bytes  = SIZE_BITS'(need_ff);
                     put_pend_in       = 1'b1;
                     put_addr_in       = best_ff;
                     put_data_in.ofs   = OFFSET_BITS'(E_W'(bsel_ff.ofs) + E_W'(need_ff));
                     put_data_in.bytes = SIZE_BITS'(head_ff);
                     state_in          = S_PUT;
                  end
               end
            end else begin
               if (count_ff == '0) begin
                  ins_req = 1'b1;
                  ins_k   = '0;
               end else if (ofs_ff < bsel_ff.ofs) begin
                  if (rel_end == E_W'(bsel_ff.ofs)) begin
                     put_pend_in       = 1'b1;
                     put_addr_in       = '0;
                     put_data_in.ofs   = ofs_ff;
                     put_data_in.bytes = SIZE_BITS'(E_W'(bsel_ff.bytes) + E_W'(size_ff));
                     state_in          = S_PUT;
                  end else begin
                     ins_req = 1'b1;
                     ins_k   = '0;
                  end
               end else if (E_W'(bsel_ff.ofs) + E_W'(bsel_ff.bytes) == E_W'(ofs_ff)) begin
                  put_pend_in     = 1'b1;
                  put_addr_in     = below_ff;
                  put_data_in.ofs = bsel_ff.ofs;
                  if (has_next_ff && rel_end == E_W'(nsel_ff.ofs)) begin
                     put_data_in.bytes = SIZE_BITS'(E_W'(bsel_ff.bytes) + E_W'(size_ff)
                                                    + E_W'(nsel_ff.bytes));
                     mode_rm_in        = 1'b1;
                     cur_in            = below_ff + 1'b1;
                     lim_in            = count_ff - 1'b1;
                     count_in          = count_ff - 1'b1;
                     state_in          = S_SHIFT_RD;
                  end else begin
                     put_data_in.bytes = SIZE_BITS'(E_W'(bsel_ff.bytes) + E_W'(size_ff));
                     state_in          = S_PUT;
                  end
               end else if (has_next_ff && rel_end == E_W'(nsel_ff.ofs)) begin
                  put_pend_in       = 1'b1;
                  put_addr_in       = below_ff + 1'b1;
                  put_data_in.ofs   = ofs_ff;
                  put_data_in.bytes = SIZE_BITS'(E_W'(nsel_ff.bytes) + E_W'(size_ff));
                  state_in          = S_PUT;
               end else begin
                  ins_req = 1'b1;
                  ins_k   = below_ff + 1'b1;
               end
               if (ins_req && count_ff < SEG_CW'(MAX_SEGMENTS)) begin
                  mode_rm_in        = 1'b0;
                  cur_in            = count_ff;
                  lim_in            = ins_k;
                  count_in          = count_ff + 1'b1;
                  put_pend_in       = 1'b1;
                  put_addr_in       = ins_k;
                  put_data_in.ofs   = ofs_ff;
                  put_data_in.bytes = size_ff;
                  state_in          = S_SHIFT_RD;
               end
            end
         end

         S_SHIFT_RD: begin
            if (mode_rm_ff ? (cur_ff < lim_ff) : (cur_ff > lim_ff)) begin
               seg_raddr = mode_rm_ff ? SEG_IW'(cur_ff + 1'b1) : SEG_IW'(cur_ff - 1'b1);
               state_in  = S_SHIFT_WR;
            end else begin
               state_in = put_pend_ff ? S_PUT : S_MAX;
            end
         end

         S_SHIFT_WR: begin
            seg_we    = 1'b1;
            seg_waddr = cur_ff[SEG_IW-1:0];
            seg_wdata = seg_rdata_ff;
            cur_in    = mode_rm_ff ? cur_ff + 1'b1 : cur_ff - 1'b1;
            state_in  = S_SHIFT_RD;
         end

         S_PUT: begin
            seg_we    = 1'b1;
            seg_waddr = put_addr_ff[SEG_IW-1:0];
            seg_wdata = put_data_ff;
            state_in  = S_MAX;
         end

         S_MAX: begin
            if (pend_ff && seg_rdata_ff.bytes > max_ff) begin
               max_in = seg_rdata_ff.bytes;
            end
            if (idx_ff < IDX_W'(count_ff)) begin
               pend_in = 1'b1;
               pidx_in = idx_ff;
               idx_in  = idx_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = S_RESP;
               end
            end
         end

         S_RESP: begin
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (state_in != state_ff) begin
         idx_in  = '0;
         pend_in = 1'b0;
         if (state_in == S_MAX) begin
            max_in = '0;
         end
      end

      if (reset || csr_we) begin
         seg_we          = 1'b1;
         seg_waddr       = '0;
         seg_wdata.ofs   = '0;
         seg_wdata.bytes = reset ? POOL_RESET : csr_wdata;
         count_in        = SEG_CW'(1);
         used_in         = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (seg_we) begin
         seg_mem[seg_waddr] <= seg_wdata;
      end
      seg_rdata_ff <= seg_mem[seg_raddr];
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      slot_rdata_ff <= slot_mem[slot_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= SEG_CW'(1);
         used_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         used_ff  <= used_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      need_ff     <= need_in;
      ofs_ff      <= ofs_in;
      size_ff     <= size_in;
      slot_ff     <= slot_in;
      found_ff    <= found_in;
      head_ff     <= head_in;
      best_ff     <= best_in;
      bsel_ff     <= bsel_in;
      nsel_ff     <= nsel_in;
      has_next_ff <= has_next_in;
      below_ff    <= below_in;
      idx_ff      <= idx_in;
      pidx_ff     <= pidx_in;
      mode_rm_ff  <= mode_rm_in;
      cur_ff      <= cur_in;
      lim_ff      <= lim_in;
      put_pend_ff <= put_pend_in;
      put_addr_ff <= put_addr_in;
      put_data_ff <= put_data_in;
      status_ff   <= status_in;
      granted_ff  <= granted_in;
      max_ff      <= max_in;
   end

   assign busy                    = (state_ff != S_IDLE);
   assign rsp_strobe              = (state_ff == S_RESP);
   assign rsp_data.status         = status_ff;
   assign rsp_data.granted_offset = 16'(granted_ff);
   assign rsp_data.largest_free   = max_ff;

   a_strobe_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy)
      else $error("response strobe not followed by idle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= SEG_CW'(MAX_SEGMENTS))
      else $error("segment count out of range");

   a_fail_no_grant: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status != ST_OK) |-> rsp_data.granted_offset == '0)
      else $error("grant offset on failed request");

   a_csr_init: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> (count_ff == SEG_CW'(1) && used_ff == '0))
      else $error("pool size write did not reinitialize");

endmodule
